[sv/softclip_score_spreader_top_defines.svh]
// Assertion macros for the softclip score spreader checker.
`ifndef SOFTCLIP_SCORE_SPREADER_TOP_DEFINES_SVH
`define SOFTCLIP_SCORE_SPREADER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssp check failed");

// next-cycle implication, sampled on clk, off during reset
`define SSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssp check failed");

`endif

[sv/ssp_pkg.sv]
package ssp_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned SUM_W     = 24;
	localparam int unsigned SCORE_W   = 16;
	localparam int unsigned CLIP_W    = 10;
	localparam int unsigned QUO_W     = 16;
	localparam int unsigned ONE_Q12   = 4096;

	// register index, taken from paddr[2]
	localparam logic REG_MIN_CLIP = 1'b0;
	localparam logic REG_SQUASH   = 1'b1;

	localparam logic [CLIP_W-1:0] MIN_CLIP_RST = CLIP_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_PUSH
	} seq_state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

[sv/softclip_score_spreader_top.sv]
// Softclip score spreader.
// Input channel item_valid/item_ready carries one word: score (Q4.12) and
// softclip_count. Output channel result_valid/result_ready returns exactly
// one word per input word, spread_value, in input order.
// Config is an APB-style port: min_clip_count at 0x0, squash_mode at 0x4;
// pready is tied high, writes land on the access cycle. Write only when idle.
// Each word walks the DELAY_DEPTH-entry history memory once, one entry per
// cycle through a read-add-write pipeline. Squash mode adds the 17-step
// serial divider plus handshake before the result is pushed.
// item_ready is high only while the sequencer is idle, so a new word is
// taken only once the last one has been pushed to the output register.
// The output register holds one finished word; a new input word is taken
// while it waits. If the receiver stalls, the next word finishes its walk
// and then waits in the push step until the output register frees up.
// Reset (arst_n low) clears both delay lines and the forward-spread history
// through per-entry valid bits, so no clearing pass is needed; registers
// return to min_clip_count = 1, squash_mode = 0.
module softclip_score_spreader_top #(
	parameter int unsigned DELAY_DEPTH = ssp_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [ssp_pkg::SCORE_W-1:0]        score,
	input  logic [ssp_pkg::CLIP_W-1:0]         softclip_count,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [ssp_pkg::SUM_W-1:0]          spread_value
);
	import ssp_pkg::*;

	localparam int unsigned AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	localparam int unsigned CW = $clog2(DELAY_DEPTH + 1);     // index / radius
	localparam int unsigned PW = $clog2(DELAY_DEPTH + 2);     // forward count
	localparam int unsigned XW = PW + 1;
	localparam int unsigned EW = SUM_W + SCORE_W + PW;        // history entry
	localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DELAY_DEPTH - 1);

	// config registers
	logic [CLIP_W-1:0] min_clip_q;
	logic              squash_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_clip_q <= MIN_CLIP_RST;
			squash_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MIN_CLIP: min_clip_q <= pwdata[CLIP_W-1:0];
				REG_SQUASH:   squash_q   <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIN_CLIP: prdata = {{(32-CLIP_W){1'b0}}, min_clip_q};
			REG_SQUASH:   prdata = {31'b0, squash_q};
			default:      prdata = '0;
		endcase
	end

	// history memory: {spread sum, raw score, forward count} per position
	logic [EW-1:0]          mem [DELAY_DEPTH];
	logic [DELAY_DEPTH-1:0] vld_q;
	logic [EW-1:0]          rdata_q;
	logic                   rvld_q;
	logic                   mem_we;
	logic [AW-1:0]          waddr;
	logic [EW-1:0]          wdata;

	// sequencer and item state
	seq_state_t        state_q, state_d;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     rp_q;
	logic [CW-1:0]     rcnt_q;
	logic              v_s1;
	logic [CW-1:0]     i_s1;
	logic [AW-1:0]     addr_s1;
	logic [SCORE_W-1:0] score_q;
	logic              spread_q;
	logic [CW-1:0]     rad_q;
	logic [PW-1:0]     left_q;
	logic [SUM_W-1:0]  own_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SCORE_W-1:0] orig_q;
	logic              res_valid_q;
	logic [SUM_W-1:0]  res_value_q;

	logic              accept;
	logic              out_free;
	logic              walk_end;
	logic              push_go;
	div_ctl_t          div_ctl;
	div_sts_t          div_sts;
	logic [QUO_W-1:0]  quo;

	// walk datapath on the registered read
	logic [EW-1:0]      ent;
	logic [SUM_W-1:0]   ent_spread;
	logic [SCORE_W-1:0] ent_score;
	logic [PW-1:0]      ent_left;
	logic               hit_add;
	logic               hit_own;
	logic [SUM_W-1:0]   spread_new;

	// accept-side decode
	logic               in_spread;
	logic [CW-1:0]      in_rad;
	logic [12:0]        orig_cap;
	logic [SUM_W:0]     div_den;

	assign accept   = item_valid & item_ready;
	assign out_free = !res_valid_q || result_ready;
	assign walk_end = (rcnt_q == DEPTH_C) && !v_s1;
	assign push_go  = (state_q == ST_PUSH) && out_free;

	assign in_spread = (softclip_count >= min_clip_q);
	assign in_rad    = (11'(softclip_count) < 11'(DELAY_DEPTH)) ?
		CW'(softclip_count) : DEPTH_C;

	assign ent        = rvld_q ? rdata_q : '0;
	assign ent_spread = ent[EW-1 -: SUM_W];
	assign ent_score  = ent[PW +: SCORE_W];
	assign ent_left   = ent[PW-1:0];
	// entry i (from the oldest) is among the r newest when i + r >= depth
	assign hit_add    = spread_q && ((XW'(i_s1) + XW'(rad_q)) >= XW'(DELAY_DEPTH));
	// entry at age depth-i still spreads forward onto this position
	assign hit_own    = (XW'(ent_left) + XW'(i_s1)) > XW'(DELAY_DEPTH);
	assign spread_new = sat_add(ent_spread, hit_add ? SUM_W'(score_q) : '0);

	assign orig_cap = (orig_q >= SCORE_W'(ONE_Q12)) ? 13'(ONE_Q12) : orig_q[12:0];
	assign div_den  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(ONE_Q12) - (SUM_W+1)'(orig_cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		item_ready    = 1'b0;
		div_ctl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_end) begin
					if (squash_q) begin
						state_d       = ST_DIV;
						div_ctl.start = 1'b1;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_DIV: begin
				if (div_sts.done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory write port: walk write-back, then the push of the new position
	always_comb begin
		mem_we = 1'b0;
		waddr  = addr_s1;
		wdata  = {spread_new, ent_score, ent_left};
		if (state_q == ST_WALK && v_s1 && i_s1 != '0) begin
			mem_we = 1'b1;
		end else if (push_go) begin
			mem_we = 1'b1;
			waddr  = head_q;
			wdata  = {own_q, score_q, left_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[rp_q];
			if (mem_we) vld_q[waddr] <= 1'b1;
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			rp_q   <= '0;
			rcnt_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				rp_q   <= head_q;
				rcnt_q <= '0;
				v_s1   <= 1'b0;
			end else if (state_q == ST_WALK) begin
				if (rcnt_q != DEPTH_C) begin
					rcnt_q <= rcnt_q + CW'(1);
					rp_q   <= (rp_q == LAST_A) ? '0 : rp_q + AW'(1);
					v_s1   <= 1'b1;
				end else begin
					v_s1 <= 1'b0;
				end
			end
			if (push_go) head_q <= (head_q == LAST_A) ? '0 : head_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && rcnt_q != DEPTH_C) begin
			i_s1    <= rcnt_q;
			addr_s1 <= rp_q;
		end
	end

	// item payload and accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			score_q  <= score;
			spread_q <= in_spread;
			rad_q    <= in_rad;
			left_q   <= in_spread ? PW'(in_rad) + PW'(1) : '0;
			// own score, plus its own forward spread onto this position
			own_q    <= in_spread ? SUM_W'({score, 1'b0}) : SUM_W'(score);
		end else if (state_q == ST_WALK && v_s1) begin
			if (hit_own) own_q <= sat_add(own_q, SUM_W'(ent_score));
			if (i_s1 == '0) begin
				// oldest entry leaves the line
				sum_q  <= spread_new;
				orig_q <= ent_score;
			end
		end
	end

	ssp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (sum_q),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (quo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push_go) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_go) res_value_q <= squash_q ? SUM_W'(quo) : sum_q;
	end

	assign result_valid = res_valid_q;
	assign spread_value = res_value_q;

endmodule

[sv/ssp_div.sv]
// Restoring divider, one quotient bit per cycle, 17 steps.
// Quotient is at most 2^16 since num <= den; a full 17-bit result saturates.
module ssp_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ssp_pkg::div_ctl_t                    ctl,
	input  logic [ssp_pkg::SUM_W-1:0]            num,
	input  logic [ssp_pkg::SUM_W:0]              den,
	output ssp_pkg::div_sts_t                    sts,
	output logic [ssp_pkg::QUO_W-1:0]            quo
);
	import ssp_pkg::*;

	localparam int unsigned STEPS = QUO_W + 1;
	localparam int unsigned RW    = SUM_W + 2;

	logic [RW-1:0]    rem_q;
	logic [SUM_W:0]   den_q;
	logic [QUO_W:0]   quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             zero_q;

	logic [RW:0]      diff;
	logic             bit_ok;
	logic [RW-1:0]    rem_nxt;

	assign diff    = {1'b0, rem_q} - {2'b0, den_q};
	assign bit_ok  = !diff[RW];
	assign rem_nxt = bit_ok ? diff[RW-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= RW'(num);
			den_q  <= den;
			quo_q  <= '0;
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= {rem_nxt[RW-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-1:0], bit_ok};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo = zero_q ? '0 : (quo_q[QUO_W] ? {QUO_W{1'b1}} : quo_q[QUO_W-1:0]);

endmodule

[sv/ssp_checker.sv]
module ssp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [ssp_pkg::SUM_W-1:0]     spread_value
);
`include "softclip_score_spreader_top_defines.svh"

	// stalled result word holds
	`SSP_ASSERT_NXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(spread_value))
	// one word at a time: busy right after an accept
	`SSP_ASSERT_NXT(a_busy_after_acc, item_valid && item_ready, !item_ready)
	// a result never appears the cycle after an accept into an empty output
	`SSP_ASSERT_NXT(a_no_fast_res, item_valid && item_ready && !result_valid, !result_valid)
	// a new result is loaded only from the push step, never while idle
	`SSP_ASSERT_IMP(a_res_from_push, $rose(result_valid), $past(!item_ready))

endmodule

bind softclip_score_spreader_top ssp_checker u_ssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.spread_value (spread_value)
);

[sim/softclip_score_spreader_top_test.sv]
`timescale 1ns / 100ps

module softclip_score_spreader_top_test;
	import ssp_pkg::*;

	localparam int unsigned DEPTH        = DEPTH_DEF;
	localparam int unsigned FWD_SLOTS    = DEPTH + 1;
	localparam int unsigned SUM_MAX      = (1 << SUM_W) - 1;
	localparam int unsigned QUO_MAX      = (1 << QUO_W) - 1;
	// no word or register write for this long means the block is stuck
	localparam int unsigned STUCK_LIMIT  = 2000;
	// settle time after the last word, well past the squash-mode latency
	localparam int unsigned TAIL_CYCLES  = 64;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_WORDS  = 122;

	// Predicts spread_value for every input word, in order, and checks
	// the words coming back against it.
	class spread_predictor;
		logic [CLIP_W-1:0]  min_clip;
		logic               squash;
		logic [SUM_W-1:0]   sum_hist[DEPTH];
		logic [SCORE_W-1:0] score_hist[DEPTH];
		int unsigned        oldest;
		int unsigned        fwd_left[FWD_SLOTS];
		logic [SCORE_W-1:0] fwd_score[FWD_SLOTS];
		logic [SUM_W-1:0]   expected_spread[$];
		int unsigned        errors;

		function new();
			min_clip = MIN_CLIP_RST;
			squash   = 1'b0;
			oldest   = 0;
			errors   = 0;
			foreach (sum_hist[i]) begin
				sum_hist[i]   = '0;
				score_hist[i] = '0;
			end
			foreach (fwd_left[i]) begin
				fwd_left[i]  = 0;
				fwd_score[i] = '0;
			end
		endfunction

		function logic [SUM_W-1:0] clamp_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
			longint unsigned s;
			s = 64'(a) + 64'(b);
			return (s > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(s);
		endfunction

		function void take_word(logic [SCORE_W-1:0] sc, logic [CLIP_W-1:0] cl);
			int unsigned        radius;
			int unsigned        idx;
			logic [SUM_W-1:0]   own;
			logic [SUM_W-1:0]   held;
			logic [SCORE_W-1:0] held_score;
			longint unsigned    capped;
			longint unsigned    den;
			longint unsigned    quo;
			if (cl >= min_clip) begin
				radius = (cl < DEPTH) ? cl : DEPTH;
				// raise the newest radius entries of the history
				for (int unsigned i = DEPTH - radius; i < DEPTH; i++) begin
					idx = (oldest + i) % DEPTH;
					sum_hist[idx] = clamp_add(sum_hist[idx], SUM_W'(sc));
				end
				// forward spread covers this position plus radius more
				for (int unsigned i = 0; i < FWD_SLOTS; i++) begin
					if (fwd_left[i] == 0) begin
						fwd_left[i]  = radius + 1;
						fwd_score[i] = sc;
						break;
					end
				end
			end
			own = SUM_W'(sc);
			for (int unsigned i = 0; i < FWD_SLOTS; i++) begin
				if (fwd_left[i] != 0) begin
					own = clamp_add(own, SUM_W'(fwd_score[i]));
					fwd_left[i]--;
					if (fwd_left[i] == 0)
						fwd_score[i] = '0;
				end
			end
			held             = sum_hist[oldest];
			held_score       = score_hist[oldest];
			sum_hist[oldest] = own;
			score_hist[oldest] = sc;
			oldest           = (oldest + 1) % DEPTH;
			if (squash) begin
				capped = (held_score < ONE_Q12) ? held_score : ONE_Q12;
				den    = 64'(held) + ONE_Q12 - capped;
				quo    = 0;
				if (den != 0) begin
					quo = (64'(held) << 16) / den;
					if (quo > QUO_MAX)
						quo = QUO_MAX;
				end
				expected_spread.push_back(SUM_W'(quo));
			end else begin
				expected_spread.push_back(held);
			end
		endfunction

		function void check_word(logic [SUM_W-1:0] got);
			logic [SUM_W-1:0] want;
			if (expected_spread.size() == 0) begin
				$display("%0t: spread_value expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_spread.pop_front();
			if (got !== want) begin
				$display("%0t: spread_value expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid;
	logic               item_ready;
	logic [SCORE_W-1:0] score;
	logic [CLIP_W-1:0]  softclip_count;
	logic               result_valid;
	logic               result_ready;
	logic [SUM_W-1:0]   spread_value;

	spread_predictor spread_pred;
	// set during phases that run with no gaps on either side
	logic            no_idle = 1'b0;
	int unsigned     stall_left = 0;
	int unsigned     stuck_cycles = 0;
	int unsigned     clip_plan[PHASES] = '{1, 0, 16, 1023, 17, 0, 2, 5};

	softclip_score_spreader_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.score          (score),
		.softclip_count (softclip_count),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.spread_value   (spread_value)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap length: mostly none, some short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Scores lean on the interesting spots: zero, full scale, and both
	// sides of 1.0, which is where the squash ratio changes behavior.
	function automatic logic [SCORE_W-1:0] rand_score();
		case ($urandom_range(9))
			0, 1, 2, 3: return SCORE_W'($urandom_range(0, 65535));
			4, 5:       return SCORE_W'($urandom_range(0, ONE_Q12 - 1));
			6:          return '1;
			7:          return '0;
			default:    return SCORE_W'($urandom_range(ONE_Q12, 12000));
		endcase
	endfunction

	// Counts mostly small, so radii below, at and above the depth all show.
	function automatic logic [CLIP_W-1:0] rand_clips();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return CLIP_W'($urandom_range(0, 20));
			6, 7:             return CLIP_W'($urandom_range(0, 1023));
			8:                return '1;
			default:          return CLIP_W'(DEPTH);
		endcase
	endfunction

	// Receiver: result_ready may drop for a random stretch after each high cycle.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			stall_left   <= no_idle ? 0 : pick_gap();
		end
	end

	// Every returned word goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			spread_pred.check_word(spread_value);
	end

	// Watchdog: anything moving on either channel or the register port
	// counts as progress.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where the access cycle completes.
	task automatic reg_write(input logic reg_sel, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_MIN_CLIP)
			spread_pred.min_clip = val[CLIP_W-1:0];
		else
			spread_pred.squash = val[0];
	endtask

	// Send one word. item_valid is left high after the accept so that a
	// back-to-back word just changes the payload at the next falling edge.
	task automatic send_word(input logic [SCORE_W-1:0] sc, input logic [CLIP_W-1:0] cl);
		int unsigned gap;
		gap = no_idle ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid     <= 1'b1;
		score          <= sc;
		softclip_count <= cl;
		do @(posedge clk); while (!item_ready);
		spread_pred.take_word(sc, cl);
	endtask

	// Drop item_valid so the last word is not taken again, then hold off
	// until every outstanding result is back; the block is idle then.
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (spread_pred.expected_spread.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		spread_pred    = new();
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		item_valid     = 1'b0;
		score          = '0;
		softclip_count = '0;
		result_ready   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Raw mode, every count spreads.
		reg_write(REG_MIN_CLIP, 32'd0);
		reg_write(REG_SQUASH, 32'd0);
		send_word('0, '0);                        // zero radius, zero score
		send_word(16'hFFFF, '1);                  // count far past depth: full radius
		repeat (6)
			send_word(16'hFFFF, CLIP_W'(DEPTH));  // full radius, heavy stacking
		send_word(16'h0001, 10'd1);
		send_word(16'h8000, 10'h200);
		send_word(16'h7FFF, 10'h1FF);

		// Squash mode with the highest threshold. The full-scale scores above
		// come out of the line here, giving the ratio-of-one saturation.
		wait_drained();
		reg_write(REG_MIN_CLIP, 32'd1023);
		reg_write(REG_SQUASH, 32'd1);
		send_word(16'h1000, '1);                  // exactly 1.0, spreads
		send_word(16'hFFFF, 10'd1022);            // one short of threshold
		send_word('0, '0);
		repeat (9)
			send_word(16'h0FFF, 10'd5);           // just under 1.0

		// Random phases; each boundary drains the block before the writes.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			reg_write(REG_MIN_CLIP, (p == 5) ? $urandom_range(0, 1023) : clip_plan[p]);
			reg_write(REG_SQUASH, p % 2);
			no_idle = (p == 2 || p == 5);
			repeat (PHASE_WORDS)
				send_word(rand_score(), rand_clips());
		end

		@(negedge clk);
		item_valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (spread_pred.errors == 0 && spread_pred.expected_spread.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/ssp_pkg.sv
sv/ssp_div.sv
sv/softclip_score_spreader_top.sv
sv/ssp_checker.sv
sim/softclip_score_spreader_top_test.sv
